// ----- design/pending_value_match_table_defines.svh -----
// Assertion macros used by the table design file.
`ifndef PENDING_VALUE_MATCH_TABLE_DEFINES_SVH
`define PENDING_VALUE_MATCH_TABLE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PVMT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PVMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pvmt_pkg.sv -----
package pvmt_pkg;

  localparam int SLOT_COUNT      = 8;
  localparam int MAX_VALUE_BYTES = 8;
  localparam int KEY_BITS        = 32;
  localparam int VALUE_BITS      = 64;
  localparam int SIZE_BITS       = 4;
  localparam int IDX_W           = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [1:0] OP_REMEMBER = 2'd0;
  localparam logic [1:0] OP_CONSUME  = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_NO_MATCH = 2'd3;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [SIZE_BITS-1:0]  size;
    logic [VALUE_BITS-1:0] value;
  } slot_entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    slot_entry_t       wr_data;
    logic [IDX_W-1:0]  rd_addr;
  } ram_req_t;

  function automatic logic [VALUE_BITS-1:0] byte_mask(input logic [SIZE_BITS-1:0] size);
    logic [VALUE_BITS-1:0] mask;
    mask = '0;
    for (int b = 0; b < VALUE_BITS / 8; b++) begin
      if (SIZE_BITS'(b) < size) begin
        mask[b*8 +: 8] = 8'hff;
      end
    end
    return mask;
  endfunction

endpackage

// ----- design/pvmt_slot_ram.sv -----
module pvmt_slot_ram (
  input  logic                 clk,
  input  pvmt_pkg::ram_req_t   req,
  output pvmt_pkg::slot_entry_t rd_data
);

  pvmt_pkg::slot_entry_t slot_mem [pvmt_pkg::SLOT_COUNT];
  pvmt_pkg::slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      slot_mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= slot_mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/pending_value_match_table.sv -----
// Table of expected values keyed by an opaque key. Each request remembers a value, consumes a
// matching value or clears a key, and returns one status. Slot contents live in a synchronous
// memory read one slot per cycle; valid bits are flip-flops cleared by reset. A remember or
// consume with a bad size, or an unused op, goes straight to the reply; any other request scans
// the slots in order until a matching slot is found or the last slot is read. The slot memory has
// a single read port, so the scan reads one slot at a time. A finished status
// waits in an output register while the next request is accepted.
`include "pending_value_match_table_defines.svh"

module pending_value_match_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_key,
  input  logic [63:0] in_value,
  input  logic [3:0]  in_value_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_REPLY = 3'b100
  } state_t;

  localparam logic [pvmt_pkg::IDX_W-1:0] LAST_IDX =
    pvmt_pkg::IDX_W'(pvmt_pkg::SLOT_COUNT - 1);

  state_t                              state_r, state_nxt;
  logic [1:0]                          op_r, op_nxt;
  logic [pvmt_pkg::KEY_BITS-1:0]       key_r, key_nxt;
  logic [pvmt_pkg::VALUE_BITS-1:0]     value_r, value_nxt;
  logic [pvmt_pkg::SIZE_BITS-1:0]      size_r, size_nxt;
  logic [1:0]                          status_r, status_nxt;
  logic [pvmt_pkg::IDX_W-1:0]          addr_r, addr_nxt;
  logic                                rd_vld_r, rd_vld_nxt;
  logic [pvmt_pkg::IDX_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic [pvmt_pkg::SLOT_COUNT-1:0]     valid_r, valid_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [1:0]                          out_status_r, out_status_nxt;

  pvmt_pkg::ram_req_t    ram_req;
  pvmt_pkg::slot_entry_t rd_entry;

  logic                       in_acc;
  logic                       bad_size;
  logic                       key_hit;
  logic                       full_hit;
  logic                       scan_last;
  logic                       free_any;
  logic [pvmt_pkg::IDX_W-1:0] free_idx;

  pvmt_slot_ram u_slot_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_entry)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  assign bad_size = (in_value_size == '0) ||
                    (in_value_size > pvmt_pkg::SIZE_BITS'(pvmt_pkg::MAX_VALUE_BYTES));

  assign key_hit  = rd_vld_r && valid_r[rd_idx_r] && (rd_entry.key == key_r);
  assign full_hit = key_hit && ((op_r != pvmt_pkg::OP_CONSUME) ||
                    ((rd_entry.size == size_r) && (rd_entry.value == value_r)));
  assign scan_last = rd_vld_r && (rd_idx_r == LAST_IDX);

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = pvmt_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = pvmt_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    size_nxt       = size_r;
    status_nxt     = status_r;
    addr_nxt       = addr_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;

    ram_req.wr_en         = 1'b0;
    ram_req.wr_addr       = rd_idx_r;
    ram_req.wr_data.key   = key_r;
    ram_req.wr_data.size  = size_r;
    ram_req.wr_data.value = value_r;
    ram_req.rd_addr       = addr_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_op;
          key_nxt   = in_key[pvmt_pkg::KEY_BITS-1:0];
          value_nxt = in_value & pvmt_pkg::byte_mask(in_value_size);
          size_nxt  = in_value_size;
          addr_nxt  = '0;
          if (((in_op == pvmt_pkg::OP_REMEMBER) || (in_op == pvmt_pkg::OP_CONSUME)) &&
              bad_size) begin
            status_nxt = pvmt_pkg::STATUS_BAD_SIZE;
            state_nxt  = S_REPLY;
          end else if ((in_op == pvmt_pkg::OP_REMEMBER) || (in_op == pvmt_pkg::OP_CONSUME) ||
                       (in_op == pvmt_pkg::OP_CLEAR)) begin
            state_nxt = S_SCAN;
          end else begin
            status_nxt = pvmt_pkg::STATUS_DONE;
            state_nxt  = S_REPLY;
          end
        end
      end
      S_SCAN: begin
        if (addr_r != LAST_IDX) begin
          addr_nxt = addr_r + 1'b1;
        end
        if (full_hit) begin
          status_nxt = pvmt_pkg::STATUS_DONE;
          state_nxt  = S_REPLY;
          if (op_r == pvmt_pkg::OP_REMEMBER) begin
            ram_req.wr_en = 1'b1;
          end else begin
            valid_nxt[rd_idx_r] = 1'b0;
          end
        end else if (scan_last) begin
          state_nxt = S_REPLY;
          if (op_r == pvmt_pkg::OP_REMEMBER) begin
            if (free_any) begin
              ram_req.wr_en       = 1'b1;
              ram_req.wr_addr     = free_idx;
              valid_nxt[free_idx] = 1'b1;
              status_nxt          = pvmt_pkg::STATUS_DONE;
            end else begin
              status_nxt = pvmt_pkg::STATUS_FULL;
            end
          end else if (op_r == pvmt_pkg::OP_CONSUME) begin
            status_nxt = pvmt_pkg::STATUS_NO_MATCH;
          end else begin
            status_nxt = pvmt_pkg::STATUS_DONE;
          end
        end
      end
      S_REPLY: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rd_vld_nxt = (state_r == S_SCAN) && (state_nxt == S_SCAN);
    rd_idx_nxt = addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    value_r      <= value_nxt;
    size_r       <= size_nxt;
    status_r     <= status_nxt;
    addr_r       <= addr_nxt;
    rd_idx_r     <= rd_idx_nxt;
    out_status_r <= out_status_nxt;
  end

  `PVMT_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r != S_IDLE, "accept stayed idle")
  `PVMT_ASSERT_SAME(a_write_in_scan, ram_req.wr_en, state_r == S_SCAN, "slot write outside scan")
  `PVMT_ASSERT_NEXT(a_write_sets_valid, ram_req.wr_en, valid_r[$past(ram_req.wr_addr)], "not valid")

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS = 730;
  localparam int KEY_POOL    = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 30;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]                      op;
    logic [pvmt_pkg::KEY_BITS-1:0]   key;
    logic [pvmt_pkg::VALUE_BITS-1:0] value;
    logic [pvmt_pkg::SIZE_BITS-1:0]  size;
  } table_req_t;

  logic                            clk           = 1'b0;
  logic                            rst_n         = 1'b0;
  logic                            in_valid      = 1'b0;
  logic                            in_stall;
  logic [1:0]                      in_op         = pvmt_pkg::OP_REMEMBER;
  logic [pvmt_pkg::KEY_BITS-1:0]   in_key        = '0;
  logic [pvmt_pkg::VALUE_BITS-1:0] in_value      = '0;
  logic [pvmt_pkg::SIZE_BITS-1:0]  in_value_size = '0;
  logic                            out_valid;
  logic                            out_stall     = 1'b0;
  logic [1:0]                      out_status;

  table_req_t  pending_reqs[$];
  logic [1:0]  status_expected[$];
  table_req_t  cur_req;
  int          total_reqs     = 0;
  int          accepted_count = 0;
  int          fail_count     = 0;
  int          burst_left     = 0;
  int          gap_left       = 0;
  int          cycle_count    = 0;
  logic        draining       = 1'b0;

  // Shadow copy of the slot table.
  logic                            slot_used  [pvmt_pkg::SLOT_COUNT];
  logic [pvmt_pkg::KEY_BITS-1:0]   slot_key_q [pvmt_pkg::SLOT_COUNT];
  logic [pvmt_pkg::VALUE_BITS-1:0] slot_val_q [pvmt_pkg::SLOT_COUNT];
  logic [pvmt_pkg::SIZE_BITS-1:0]  slot_size_q[pvmt_pkg::SLOT_COUNT];

  pending_value_match_table DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_key       (in_key),
    .in_value     (in_value),
    .in_value_size(in_value_size),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status)
  );

  always #6 clk = ~clk;

  function automatic logic [pvmt_pkg::VALUE_BITS-1:0] size_mask(
      logic [pvmt_pkg::SIZE_BITS-1:0] n);
    if (n >= 8) return '1;
    return (pvmt_pkg::VALUE_BITS'(1) << (8 * n)) - pvmt_pkg::VALUE_BITS'(1);
  endfunction

  function automatic void free_slot_at(int i);
    slot_used[i]   = 1'b0;
    slot_val_q[i]  = '0;
    slot_size_q[i] = '0;
  endfunction

  function automatic logic [1:0] table_apply(table_req_t r);
    logic [pvmt_pkg::VALUE_BITS-1:0] masked;
    int                              free_at;
    masked  = r.value & size_mask(r.size);
    free_at = -1;
    if ((r.op == pvmt_pkg::OP_REMEMBER || r.op == pvmt_pkg::OP_CONSUME) &&
        (r.size == 0 || r.size > pvmt_pkg::MAX_VALUE_BYTES)) begin
      return pvmt_pkg::STATUS_BAD_SIZE;
    end
    case (r.op)
      pvmt_pkg::OP_REMEMBER: begin
        for (int i = 0; i < pvmt_pkg::SLOT_COUNT; i++) begin
          if (slot_used[i] && slot_key_q[i] == r.key) begin
            slot_val_q[i]  = masked;
            slot_size_q[i] = r.size;
            return pvmt_pkg::STATUS_DONE;
          end
          if (!slot_used[i] && free_at < 0) free_at = i;
        end
        if (free_at < 0) return pvmt_pkg::STATUS_FULL;
        slot_used[free_at]   = 1'b1;
        slot_key_q[free_at]  = r.key;
        slot_val_q[free_at]  = masked;
        slot_size_q[free_at] = r.size;
      end
      pvmt_pkg::OP_CONSUME: begin
        for (int i = 0; i < pvmt_pkg::SLOT_COUNT; i++) begin
          if (slot_used[i] && slot_key_q[i] == r.key && slot_size_q[i] == r.size &&
              slot_val_q[i] == masked) begin
            free_slot_at(i);
            return pvmt_pkg::STATUS_DONE;
          end
        end
        return pvmt_pkg::STATUS_NO_MATCH;
      end
      pvmt_pkg::OP_CLEAR: begin
        for (int i = 0; i < pvmt_pkg::SLOT_COUNT; i++) begin
          if (slot_used[i] && slot_key_q[i] == r.key) begin
            free_slot_at(i);
            return pvmt_pkg::STATUS_DONE;
          end
        end
      end
      default: ;
    endcase
    return pvmt_pkg::STATUS_DONE;
  endfunction

  task automatic queue_req(logic [1:0] op, logic [pvmt_pkg::KEY_BITS-1:0] key,
                           logic [pvmt_pkg::VALUE_BITS-1:0] value,
                           logic [pvmt_pkg::SIZE_BITS-1:0] size);
    table_req_t r;
    r.op    = op;
    r.key   = key;
    r.value = value;
    r.size  = size;
    pending_reqs.push_back(r);
  endtask

  initial begin
    logic [pvmt_pkg::KEY_BITS-1:0]   key_pool[KEY_POOL];
    logic [pvmt_pkg::VALUE_BITS-1:0] hint_value[logic [pvmt_pkg::KEY_BITS-1:0]];
    logic [pvmt_pkg::SIZE_BITS-1:0]  hint_size[logic [pvmt_pkg::KEY_BITS-1:0]];
    logic [pvmt_pkg::KEY_BITS-1:0]   k;
    logic [pvmt_pkg::VALUE_BITS-1:0] v;
    logic [pvmt_pkg::VALUE_BITS-1:0] m;
    logic [pvmt_pkg::SIZE_BITS-1:0]  sz;
    int                              roll;

    for (int i = 0; i < pvmt_pkg::SLOT_COUNT; i++) begin
      slot_used[i]   = 1'b0;
      slot_key_q[i]  = '0;
      slot_val_q[i]  = '0;
      slot_size_q[i] = '0;
    end

    queue_req(pvmt_pkg::OP_REMEMBER, '0, '1, 4'd1);
    queue_req(pvmt_pkg::OP_REMEMBER, '1, '1, 4'd8);
    queue_req(pvmt_pkg::OP_REMEMBER, 32'h1, 64'h1234, 4'd0);
    queue_req(pvmt_pkg::OP_CONSUME, '0, '0, 4'd0);
    queue_req(pvmt_pkg::OP_CONSUME, '0, 64'hA5A5_A5A5_A5A5_A5FF, 4'd1);
    queue_req(pvmt_pkg::OP_CONSUME, '0, 64'hFF, 4'd1);
    queue_req(pvmt_pkg::OP_REMEMBER, '1, 64'h0123_4567_89AB_CDEF, 4'd8);
    queue_req(pvmt_pkg::OP_CONSUME, '1, 64'h0123_4567_89AB_CDEF, 4'd7);
    queue_req(pvmt_pkg::OP_CONSUME, '1, 64'h0123_4567_89AB_CDEF, 4'd8);
    for (int i = 1; i <= pvmt_pkg::SLOT_COUNT; i++) begin
      queue_req(pvmt_pkg::OP_REMEMBER, pvmt_pkg::KEY_BITS'(i),
                pvmt_pkg::VALUE_BITS'(i * 32'h1111_1111), pvmt_pkg::SIZE_BITS'(i));
    end
    queue_req(pvmt_pkg::OP_REMEMBER, 32'd9, 64'h99, 4'd1);
    queue_req(pvmt_pkg::OP_REMEMBER, 32'd3, '0, 4'd2);
    queue_req(pvmt_pkg::OP_CLEAR, 32'd3, '1, 4'd8);
    queue_req(pvmt_pkg::OP_CLEAR, 32'd3, '0, 4'd0);
    queue_req(pvmt_pkg::OP_REMEMBER, 32'd9, 64'h99, 4'd1);
    queue_req(pvmt_pkg::OP_CONSUME, 32'd5, pvmt_pkg::VALUE_BITS'(5 * 32'h1111_1111), 4'd5);
    queue_req(pvmt_pkg::OP_CONSUME, 32'd3, '0, 4'd2);
    queue_req(pvmt_pkg::OP_CLEAR, '0, '0, 4'd0);

    // Most keys come from a small pool so that the table fills up and consumes hit.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    for (int n = 0; n < RANDOM_REQS; n++) begin
      roll = $urandom_range(99);
      k    = (roll < 10) ? pvmt_pkg::KEY_BITS'($urandom)
                         : key_pool[$urandom_range(KEY_POOL - 1)];
      v    = {$urandom, $urandom};
      sz   = pvmt_pkg::SIZE_BITS'($urandom_range(pvmt_pkg::MAX_VALUE_BYTES, 1));
      roll = $urandom_range(99);
      if (roll < 40) begin
        queue_req(pvmt_pkg::OP_REMEMBER, k, v, sz);
        hint_value[k] = v & size_mask(sz);
        hint_size[k]  = sz;
      end else if (roll < 78) begin
        if (hint_value.exists(k) && $urandom_range(3) != 0) begin
          sz = hint_size[k];
          m  = size_mask(sz);
          v  = (hint_value[k] & m) | (v & ~m);
          if ($urandom_range(9) == 0) v[8 * $urandom_range(sz - 1) +: 8] ^= 8'h01;
          hint_value.delete(k);
          hint_size.delete(k);
        end
        queue_req(pvmt_pkg::OP_CONSUME, k, v, sz);
      end else if (roll < 93) begin
        queue_req(pvmt_pkg::OP_CLEAR, k, v,
                  pvmt_pkg::SIZE_BITS'($urandom_range(pvmt_pkg::MAX_VALUE_BYTES)));
        hint_value.delete(k);
        hint_size.delete(k);
      end else begin
        queue_req(($urandom_range(1) == 0) ? pvmt_pkg::OP_REMEMBER : pvmt_pkg::OP_CONSUME,
                  k, v, '0);
      end
    end
    total_reqs = pending_reqs.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        status_expected.push_back(table_apply(cur_req));
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid      <= 1'b1;
          in_op         <= cur_req.op;
          in_key        <= cur_req.key;
          in_value      <= cur_req.value;
          in_value_size <= cur_req.size;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: two long hold-offs, otherwise a stall pattern that steps through four modes in turn.
  always @(posedge clk) begin : result_stall
    int stall_tick;
    int hold_left;
    int holds_taken;
    stall_tick++;
    if (!rst_n || draining) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_taken < 2 && accepted_count >= (holds_taken == 0 ? 120 : 480)) begin
      holds_taken++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case ((stall_tick / 40) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3) == 0);
        2: out_stall <= ($urandom_range(3) != 0);
        default: out_stall <= ((stall_tick % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin : status_monitor
    logic [1:0] expected_status;
    if (rst_n && out_valid && !out_stall) begin
      if (status_expected.size() == 0) begin
        $error("status: expected none, actual %0d", out_status);
        fail_count++;
      end else begin
        expected_status = status_expected.pop_front();
        if (out_status !== expected_status) begin
          $error("status: expected %0d, actual %0d", expected_status, out_status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    @(posedge clk);
    while (rst_n !== 1'b1 || accepted_count != total_reqs || status_expected.size() != 0) begin
      @(posedge clk);
    end
    draining <= 1'b1;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
